@@ src/ehcc_pkg.sv @@
// Shared types, character codes and helper functions for the extruder head controller.
package ehcc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_T_HI = 3'd1,
    MODE_T_LO = 3'd2,
    MODE_S_HI = 3'd3,
    MODE_S_LO = 3'd4
  } entry_mode_e;

  typedef enum logic [1:0] {
    REQ_STOP = 2'd0,
    REQ_FWD  = 2'd1,
    REQ_REV  = 2'd2
  } motor_req_e;

  // Command letters.
  localparam logic [7:0] CMD_GET_SETPOINT = 8'h74; // t
  localparam logic [7:0] CMD_SET_SETPOINT = 8'h54; // T
  localparam logic [7:0] CMD_GET_TEMP     = 8'h76; // v
  localparam logic [7:0] CMD_STOP         = 8'h6d; // m
  localparam logic [7:0] CMD_FORWARD      = 8'h46; // F
  localparam logic [7:0] CMD_REVERSE      = 8'h52; // R
  localparam logic [7:0] CMD_GET_SPEED    = 8'h73; // s
  localparam logic [7:0] CMD_SET_SPEED    = 8'h53; // S
  localparam logic [7:0] CMD_RANGE_LOW    = 8'h4c; // L
  localparam logic [7:0] CMD_RANGE_HIGH   = 8'h48; // H
  localparam logic [7:0] CMD_GET_RANGE    = 8'h6c; // l

  // Transmit characters.
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_X        = 8'h78;
  localparam logic [7:0] CHAR_QUESTION = 8'h3f;
  localparam logic [7:0] CHAR_CR       = 8'h0d;
  localparam logic [7:0] CHAR_LF       = 8'h0a;
  localparam logic [7:0] CHAR_GT       = 8'h3e;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_A_LESS10 = 8'h57; // 'a' - 10

  localparam logic [3:0] NIBBLE_MASK = 4'hf;
  localparam logic [7:0] DUTY_FULL   = 8'hff;
  localparam int unsigned MSG_BYTES  = 9;

  typedef struct packed {
    logic       heater_on;
    logic       pwm_enable;
    logic [7:0] pwm_duty;
    logic       motor_reverse;
    logic       led_pin;
    logic       adc_range_low;
  } ctrl_t;

  // One item's worth of transmit beats plus the control outputs they carry.
  typedef struct packed {
    logic                       tx_valid;
    logic [3:0]                 count;
    logic [MSG_BYTES-1:0][7:0]  bytes;
    ctrl_t                      ctrl;
  } msg_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] d8;
    d8 = {4'h0, d & NIBBLE_MASK};
    return (d >= 4'd10) ? d8 + CHAR_A_LESS10 : d8 + CHAR_ZERO;
  endfunction

  // Any byte counts as a digit; the arithmetic wraps modulo 256.
  function automatic logic [7:0] digit_val(input logic [7:0] c);
    return (c > CHAR_NINE) ? c - CHAR_A_LESS10 : c - CHAR_ZERO;
  endfunction

endpackage

@@ src/ehcc_tx_serializer.sv @@
// Result buffer that plays one item's message out as a run of output beats.
module ehcc_tx_serializer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ehcc_pkg::msg_t msg_i,
  output logic          ready_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] tx_char, [8] heater_on, [9] pwm_enable, [17:10] pwm_duty,
  // [18] motor_reverse, [19] led_pin, [20] adc_range_low, [23:21] zero
  output logic [23:0]   m_axis_tdata,
  output logic          m_axis_tuser,  // tx_valid
  output logic          m_axis_tlast
);
  import ehcc_pkg::*;

  logic                      busy_q, busy_d;
  logic [3:0]                cnt_q, cnt_d;
  logic [MSG_BYTES-1:0][7:0] bytes_q, bytes_d;
  logic                      txv_q, txv_d;
  ctrl_t                     ctrl_q, ctrl_d;
  logic                      beat;

  assign beat    = busy_q && m_axis_tready;
  assign ready_o = !busy_q || (beat && cnt_q == 4'd1);

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    txv_d   = txv_q;
    ctrl_d  = ctrl_q;
    if (load_i) begin
      busy_d  = 1'b1;
      cnt_d   = msg_i.count;
      bytes_d = msg_i.bytes;
      txv_d   = msg_i.tx_valid;
      ctrl_d  = msg_i.ctrl;
    end else if (beat) begin
      busy_d  = (cnt_q != 4'd1);
      cnt_d   = cnt_q - 4'd1;
      bytes_d = bytes_q >> 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    txv_q   <= txv_d;
    ctrl_q  <= ctrl_d;
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tuser  = txv_q;
  assign m_axis_tlast  = (cnt_q == 4'd1);
  assign m_axis_tdata  = {3'b000, ctrl_q.adc_range_low, ctrl_q.led_pin, ctrl_q.motor_reverse,
                          ctrl_q.pwm_duty, ctrl_q.pwm_enable, ctrl_q.heater_on, bytes_q[0]};

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 4'd0 && cnt_q <= 4'd9))
    else $error("beat count out of range while busy");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !m_axis_tready |=> busy_q && $stable(cnt_q))
    else $error("message advanced without a beat");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("message loaded over one still in flight");

endmodule

@@ src/extruder_head_command_controller.sv @@
// Extruder head command controller top level: command decode, digit entry and control.
// Each input beat is one main-loop pass. It is registered, decoded into a message of
// 1 to 9 output beats (echo, hex report, '?' and prompt), and the serializer then sends
// those beats one per cycle while m_axis_tready is high: 1 beat for a pass without a
// byte, up to 9 for a report command. A new pass is taken while the previous message
// drains, and waits in the input register once the serializer holds a message that
// has not reached its final beat.
module extruder_head_command_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,   // blink_divider
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [11:8] temp_code, [12] run_pin_grounded, [15:13] zero
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_char, [8] heater_on, [9] pwm_enable, [17:10] pwm_duty,
  // [18] motor_reverse, [19] led_pin, [20] adc_range_low, [23:21] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,  // tx_valid
  output logic        m_axis_tlast
);
  import ehcc_pkg::*;

  logic        in_valid_q;
  logic        kind_q;
  logic [7:0]  rx_q;
  logic [3:0]  tc_q;
  logic        pin_q;

  logic [7:0]  divider_q;
  entry_mode_e mode_q, mode_d;
  logic [7:0]  high_q, high_d;
  logic [7:0]  setpoint_q, setpoint_d;
  logic [7:0]  speed_q, speed_d;
  motor_req_e  req_q, req_d;
  logic [7:0]  fast_q, fast_d;
  logic [7:0]  slow_q, slow_d;
  logic        phase_q, phase_d;
  ctrl_t       ctrl_q, ctrl_d;

  msg_t        msg;
  logic        load, msg_ready;
  logic        byte_ok, report, qmark, prompt;
  logic [7:0]  rep_val, joined;
  motor_req_e  demand;

  assign load          = in_valid_q && msg_ready;
  assign s_axis_tready = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q <= s_axis_tuser;
      rx_q   <= s_axis_tdata[7:0];
      tc_q   <= s_axis_tdata[11:8];
      pin_q  <= s_axis_tdata[12];
    end
  end

  always_comb begin
    mode_d     = mode_q;
    high_d     = high_q;
    setpoint_d = setpoint_q;
    speed_d    = speed_q;
    req_d      = req_q;
    fast_d     = fast_q;
    slow_d     = slow_q;
    phase_d    = phase_q;
    ctrl_d     = ctrl_q;
    report     = 1'b0;
    qmark      = 1'b0;
    prompt     = 1'b0;
    rep_val    = 8'h00;
    demand     = REQ_STOP;
    byte_ok    = kind_q && (rx_q != 8'h00);
    joined     = digit_val(rx_q) | {high_q[3:0], 4'h0};

    msg          = '0;
    msg.tx_valid = kind_q;
    msg.count    = 4'd1;
    if (kind_q) begin
      msg.bytes[0] = rx_q;
    end

    if (byte_ok) begin
      if (mode_q == MODE_IDLE) begin
        unique case (rx_q)
          CMD_GET_SETPOINT: begin report = 1'b1; rep_val = setpoint_q; end
          CMD_SET_SETPOINT: mode_d = MODE_T_HI;
          CMD_GET_TEMP:     begin report = 1'b1; rep_val = {4'h0, tc_q}; end
          CMD_STOP:         begin req_d = REQ_STOP; prompt = 1'b1; end
          CMD_FORWARD:      begin req_d = REQ_FWD; prompt = 1'b1; end
          CMD_REVERSE:      begin req_d = REQ_REV; prompt = 1'b1; end
          CMD_GET_SPEED:    begin report = 1'b1; rep_val = speed_q; end
          CMD_SET_SPEED:    mode_d = MODE_S_HI;
          CMD_RANGE_LOW:    begin ctrl_d.adc_range_low = 1'b1; prompt = 1'b1; end
          CMD_RANGE_HIGH:   begin ctrl_d.adc_range_low = 1'b0; prompt = 1'b1; end
          CMD_GET_RANGE: begin
            report  = 1'b1;
            rep_val = {7'h00, ctrl_q.adc_range_low};
          end
          default:          qmark = 1'b1;
        endcase
      end else begin
        unique case (mode_q)
          MODE_T_HI: begin high_d = digit_val(rx_q); mode_d = MODE_T_LO; end
          MODE_S_HI: begin high_d = digit_val(rx_q); mode_d = MODE_S_LO; end
          MODE_T_LO: begin setpoint_d = joined; mode_d = MODE_IDLE; prompt = 1'b1; end
          default:   begin speed_d = joined; mode_d = MODE_IDLE; prompt = 1'b1; end
        endcase
      end
    end

    if (report) begin
      msg.count    = 4'd9;
      msg.bytes[1] = CHAR_ZERO;
      msg.bytes[2] = CHAR_X;
      msg.bytes[3] = hex_char(rep_val[7:4]);
      msg.bytes[4] = hex_char(rep_val[3:0]);
      msg.bytes[5] = CHAR_CR;
      msg.bytes[6] = CHAR_LF;
      msg.bytes[7] = CHAR_GT;
      msg.bytes[8] = CHAR_SPACE;
    end else if (qmark) begin
      msg.count    = 4'd6;
      msg.bytes[1] = CHAR_QUESTION;
      msg.bytes[2] = CHAR_CR;
      msg.bytes[3] = CHAR_LF;
      msg.bytes[4] = CHAR_GT;
      msg.bytes[5] = CHAR_SPACE;
    end else if (prompt) begin
      msg.count    = 4'd5;
      msg.bytes[1] = CHAR_CR;
      msg.bytes[2] = CHAR_LF;
      msg.bytes[3] = CHAR_GT;
      msg.bytes[4] = CHAR_SPACE;
    end

    // Control runs only when no digit is awaited after this byte.
    if (mode_d == MODE_IDLE) begin
      if (req_d != REQ_STOP) begin
        demand = req_d;
      end else if (pin_q) begin
        demand = REQ_FWD;
      end
      ctrl_d.heater_on     = ({4'h0, tc_q} < setpoint_d);
      ctrl_d.pwm_enable    = 1'b0;
      ctrl_d.pwm_duty      = 8'h00;
      ctrl_d.motor_reverse = 1'b0;
      // The motor may run only once the head is at most one step below the setpoint.
      if ({1'b0, setpoint_d} <= ({5'h00, tc_q} + 9'd1)) begin
        if (demand == REQ_FWD) begin
          ctrl_d.pwm_enable = 1'b1;
          ctrl_d.pwm_duty   = speed_d;
        end else if (demand == REQ_REV) begin
          ctrl_d.pwm_enable    = 1'b1;
          ctrl_d.pwm_duty      = DUTY_FULL - speed_d;
          ctrl_d.motor_reverse = 1'b1;
        end
      end
      if (demand != REQ_STOP) begin
        fast_d = fast_q + 8'd1;
        if (fast_q == 8'hff) begin
          slow_d = slow_q - 8'd1;
          if (slow_q == 8'd1) begin
            slow_d         = divider_q;
            phase_d        = !phase_q;
            ctrl_d.led_pin = phase_q;
          end
        end
      end else begin
        ctrl_d.led_pin = 1'b1;
      end
    end

    msg.ctrl = ctrl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q <= 8'd16;
    end else if (cfg_we_i) begin
      divider_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      high_q     <= 8'h00;
      setpoint_q <= 8'h00;
      speed_q    <= 8'h00;
      req_q      <= REQ_STOP;
      fast_q     <= 8'h00;
      slow_q     <= 8'd16;
      phase_q    <= 1'b0;
      ctrl_q     <= '{heater_on: 1'b0, pwm_enable: 1'b0, pwm_duty: 8'h00,
                      motor_reverse: 1'b0, led_pin: 1'b0, adc_range_low: 1'b1};
    end else if (load) begin
      mode_q     <= mode_d;
      high_q     <= high_d;
      setpoint_q <= setpoint_d;
      speed_q    <= speed_d;
      req_q      <= req_d;
      fast_q     <= fast_d;
      slow_q     <= slow_d;
      phase_q    <= phase_d;
      ctrl_q     <= ctrl_d;
    end
  end

  ehcc_tx_serializer u_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .msg_i         (msg),
    .ready_o       (msg_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_pass_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !load |=> in_valid_q)
    else $error("registered pass dropped before decode");

  a_first_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && byte_ok && mode_q == MODE_T_HI |=> mode_q == MODE_T_LO)
    else $error("first setpoint digit did not advance entry");

  a_frozen_blink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && mode_q != MODE_IDLE && !byte_ok |=> $stable(fast_q) && $stable(ctrl_q))
    else $error("control advanced while digits are awaited");

endmodule
